[src/lfms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfms_pkg;

  localparam logic [1:0] MODE_FAILSAFE = 2'd0;
  localparam logic [1:0] MODE_HAND     = 2'd1;
  localparam logic [1:0] MODE_PASS     = 2'd2;

  localparam int unsigned PADDR_W = 5;

  localparam logic [2:0] REG_GS_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_MODE_RETRY  = 3'd1;
  localparam logic [2:0] REG_HAND_PERIOD = 3'd2;
  localparam logic [2:0] REG_HB_PERIOD   = 3'd3;
  localparam logic [2:0] REG_HAND_CODE   = 3'd4;
  localparam logic [2:0] REG_FS_CODE     = 3'd5;

  localparam logic [15:0] GS_TIMEOUT_RST  = 16'd3000;
  localparam logic [15:0] MODE_RETRY_RST  = 16'd1000;
  localparam logic [15:0] HAND_PERIOD_RST = 16'd20;
  localparam logic [15:0] HB_PERIOD_RST   = 16'd1000;
  localparam logic [31:0] HAND_CODE_RST   = 32'd20;
  localparam logic [31:0] FS_CODE_RST     = 32'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        gs_message_seen;
    logic        hand_link_ok;
    logic        hand_pose_valid;
    logic        fc_heartbeat_seen;
    logic [31:0] fc_mode;
    logic        link_accepts;
  } in_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic        send_heartbeat;
    logic        send_set_mode;
    logic [31:0] set_mode_value;
    logic        send_attitude;
    logic        mode_is_confirmed;
  } out_t;

endpackage

`default_nettype wire

[src/link_failover_mode_supervisor.sv]
// An accepted input beat is registered in in_q and its result then in out_q.
// Throughput: one item per cycle unless out_ready_i stalls; the whole service
// pass is one combinational step between the input and result registers.
// Reset (rst_ni low, asynchronous): failsafe, first set-mode due at once,
// all timestamps 0, configuration registers back to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module link_failover_mode_supervisor #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire lfms_pkg::in_t                in_data_i,

  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output lfms_pkg::out_t                    out_data_o,

  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfms_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration
  logic [15:0] gs_timeout_q, mode_retry_q, hand_period_q, hb_period_q;
  logic [31:0] hand_code_q, fs_code_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_timeout_q  <= lfms_pkg::GS_TIMEOUT_RST;
      mode_retry_q  <= lfms_pkg::MODE_RETRY_RST;
      hand_period_q <= lfms_pkg::HAND_PERIOD_RST;
      hb_period_q   <= lfms_pkg::HB_PERIOD_RST;
      hand_code_q   <= lfms_pkg::HAND_CODE_RST;
      fs_code_q     <= lfms_pkg::FS_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lfms_pkg::REG_GS_TIMEOUT:  gs_timeout_q  <= pwdata[15:0];
        lfms_pkg::REG_MODE_RETRY:  mode_retry_q  <= pwdata[15:0];
        lfms_pkg::REG_HAND_PERIOD: hand_period_q <= pwdata[15:0];
        lfms_pkg::REG_HB_PERIOD:   hb_period_q   <= pwdata[15:0];
        lfms_pkg::REG_HAND_CODE:   hand_code_q   <= pwdata;
        lfms_pkg::REG_FS_CODE:     fs_code_q     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lfms_pkg::REG_GS_TIMEOUT:  prdata = {16'd0, gs_timeout_q};
      lfms_pkg::REG_MODE_RETRY:  prdata = {16'd0, mode_retry_q};
      lfms_pkg::REG_HAND_PERIOD: prdata = {16'd0, hand_period_q};
      lfms_pkg::REG_HB_PERIOD:   prdata = {16'd0, hb_period_q};
      lfms_pkg::REG_HAND_CODE:   prdata = hand_code_q;
      lfms_pkg::REG_FS_CODE:     prdata = fs_code_q;
      default:                   prdata = 32'd0;
    endcase
  end

  // input and output beat registers
  logic          in_vld_q, out_vld_q;
  lfms_pkg::in_t in_q;
  lfms_pkg::out_t out_q;
  logic          proc;

  assign proc        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || proc;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // service state
  logic [1:0]  mode_q, mode_d;
  logic        tgt_hand_q, tgt_hand_d;
  logic        conf_q, conf_d;
  logic        due_q, due_d;
  logic        fc_known_q, fc_known_d;
  logic [31:0] fc_last_q, fc_last_d;
  logic        gs_ever_q, gs_ever_d;
  time_t       gs_time_q, gs_time_d;
  time_t       sm_time_q, sm_time_d;
  time_t       att_time_q, att_time_d;
  time_t       hb_time_q, hb_time_d;

  time_t          now;
  logic [1:0]     arb_mode;
  logic           gnd_live;
  logic [31:0]    tgt_code;
  lfms_pkg::out_t res;

  assign now = TIME_BITS'(in_q.now_ms);

  always_comb begin
    mode_d     = mode_q;
    tgt_hand_d = tgt_hand_q;
    conf_d     = conf_q;
    due_d      = due_q;
    sm_time_d  = sm_time_q;
    att_time_d = att_time_q;
    hb_time_d  = hb_time_q;
    res        = '0;

    gs_time_d  = in_q.gs_message_seen ? now : gs_time_q;
    gs_ever_d  = gs_ever_q || in_q.gs_message_seen;
    fc_last_d  = in_q.fc_heartbeat_seen ? in_q.fc_mode : fc_last_q;
    fc_known_d = fc_known_q || in_q.fc_heartbeat_seen;

    gnd_live = gs_ever_d && (time_t'(now - gs_time_d) <= TIME_BITS'(gs_timeout_q));

    priority if (gnd_live) begin
      arb_mode = lfms_pkg::MODE_PASS;
    end else if (in_q.hand_link_ok) begin
      arb_mode = lfms_pkg::MODE_HAND;
    end else begin
      arb_mode = lfms_pkg::MODE_FAILSAFE;
    end

    if (arb_mode != mode_q) begin
      mode_d = arb_mode;
      if (arb_mode == lfms_pkg::MODE_PASS) begin
        conf_d = 1'b1;
      end else begin
        tgt_hand_d = (arb_mode == lfms_pkg::MODE_HAND);
        conf_d     = 1'b0;
        due_d      = 1'b1;
      end
    end

    if (time_t'(now - hb_time_q) >= TIME_BITS'(hb_period_q) && in_q.link_accepts) begin
      res.send_heartbeat = 1'b1;
      hb_time_d          = now;
    end

    tgt_code = tgt_hand_d ? hand_code_q : fs_code_q;
    if (mode_d != lfms_pkg::MODE_PASS && !conf_d) begin
      if (fc_known_d && fc_last_d == tgt_code) begin
        conf_d = 1'b1;
      end else if ((due_d || time_t'(now - sm_time_q) >= TIME_BITS'(mode_retry_q))
                   && in_q.link_accepts) begin
        res.send_set_mode  = 1'b1;
        res.set_mode_value = tgt_code;
        sm_time_d          = now;
        due_d              = 1'b0;
      end
    end

    if (mode_d == lfms_pkg::MODE_HAND && in_q.hand_pose_valid && in_q.link_accepts
        && time_t'(now - att_time_q) >= TIME_BITS'(hand_period_q)) begin
      res.send_attitude = 1'b1;
      att_time_d        = now;
    end

    res.link_state        = mode_d;
    res.mode_is_confirmed = conf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      mode_q     <= lfms_pkg::MODE_FAILSAFE;
      tgt_hand_q <= 1'b0;
      conf_q     <= 1'b0;
      due_q      <= 1'b1;
      fc_known_q <= 1'b0;
      fc_last_q  <= '0;
      gs_ever_q  <= 1'b0;
      gs_time_q  <= '0;
      sm_time_q  <= '0;
      att_time_q <= '0;
      hb_time_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (proc) begin
        out_vld_q  <= 1'b1;
        mode_q     <= mode_d;
        tgt_hand_q <= tgt_hand_d;
        conf_q     <= conf_d;
        due_q      <= due_d;
        fc_known_q <= fc_known_d;
        fc_last_q  <= fc_last_d;
        gs_ever_q  <= gs_ever_d;
        gs_time_q  <= gs_time_d;
        sm_time_q  <= sm_time_d;
        att_time_q <= att_time_d;
        hb_time_q  <= hb_time_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (proc) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

[src/lfms_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfms_props (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire lfms_pkg::out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_pass_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.link_state == lfms_pkg::MODE_PASS |->
      out_data_o.mode_is_confirmed && !out_data_o.send_set_mode
      && !out_data_o.send_attitude)
    else $error("passthrough beat sends commands or is unconfirmed");

  a_sm_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send_set_mode |-> out_data_o.set_mode_value == 32'd0)
    else $error("set-mode value without set-mode");

  a_att_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_attitude |-> out_data_o.link_state == lfms_pkg::MODE_HAND)
    else $error("attitude sent outside hand control");

  a_sm_unconf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_set_mode |-> !out_data_o.mode_is_confirmed)
    else $error("set-mode sent while confirmed");

endmodule

bind link_failover_mode_supervisor lfms_props u_lfms_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
